### sv/dtq_pkg.sv
package dtq_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int TIME_W      = 63;
   localparam int PER_W       = 40;
   localparam int TAG_W       = 16;

   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [TIME_W-1:0] MIN_DELAY = TIME_W'(100);
   localparam logic [TIME_W-1:0] TIME_MAX  = '1;

   // command codes
   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [TAG_W-1:0]  timer_tag;
      logic [TIME_W-1:0] expire_time;
      logic [PER_W-1:0]  period_us;
      logic [TIME_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic              fired_valid;
      logic [TAG_W-1:0]  fired_tag;
      logic              last;
      logic              new_earliest;
      logic              full_error;
      logic              wake_valid;
      logic [TIME_W-1:0] wake_time;
      logic [TIME_W-1:0] wake_delay_us;
   } rsp_type;

   // one slot of the timer table
   typedef struct packed {
      logic [TIME_W-1:0] expiry;
      logic [PER_W-1:0]  period;
      logic [TAG_W-1:0]  tag;
   } ent_type;

   // controller to datapath
   typedef struct packed {
      logic latch_req;
      logic start_scan;
      logic decide;
      logic step;
      logic load_final;
   } dtq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic best_found;
      logic pend_valid;
      logic out_free;
      logic table_full;
      logic is_tick;
   } dtq_sts_type;

endpackage

### sv/dtq_datapath.sv
module dtq_datapath (
   input  logic                clock,
   input  logic                reset,
   input  dtq_pkg::req_type     req_data,
   input  dtq_pkg::dtq_cmd_type ctl,
   output dtq_pkg::dtq_sts_type sts,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output dtq_pkg::rsp_type     rsp_data
);
   import dtq_pkg::*;

   // slot memory, one write and one read port
   ent_type slot_mem [TABLE_DEPTH];

   req_type           req_ff, req_in;
   logic [TABLE_DEPTH-1:0] used_ff, used_in;
   logic [TABLE_DEPTH-1:0] picked_ff, picked_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [TAG_W-1:0]  pend_tag_ff, pend_tag_in;
   logic              rd_run_ff, rd_run_in;
   logic [IDX_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   ent_type           rd_ent_ff;
   logic              best_fnd_ff, best_fnd_in;
   ent_type           best_ent_ff, best_ent_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic              min_any_ff, min_any_in;
   logic [TIME_W-1:0] min_exp_ff, min_exp_in;
   logic [TIME_W-1:0] wake_t_ff, wake_t_in;
   logic              wake_ok_ff, wake_ok_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_vld_ff, rsp_vld_in;

   logic              is_add;
   logic              full;
   logic              out_free;
   logic              cur_used;
   logic              cur_pick;
   logic              cur_due;
   logic              cur_better;
   logic [IDX_W-1:0]  free_idx;
   logic [TIME_W:0]   reins_sum;
   logic [TIME_W-1:0] reins_exp;
   logic [TIME_W:0]   diff;
   logic [TIME_W-1:0] delay;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   ent_type           wr_ent;

   // lowest free slot
   function automatic logic [IDX_W-1:0] first_free(input logic [TABLE_DEPTH-1:0] used);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!used[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

   assign is_add   = (req_ff.cmd == CMD_ADD);
   assign full     = &used_ff;
   assign out_free = !rsp_vld_ff || rsp_ready;
   assign free_idx = first_free(used_ff);

   // request holding register
   assign req_in = ctl.latch_req ? req_data : req_ff;

   // scan address sequencer
   always_comb begin
      rd_run_in = rd_run_ff;
      rd_cnt_in = rd_cnt_ff;
      if (ctl.start_scan) begin
         rd_run_in = 1'b1;
         rd_cnt_in = '0;
      end else if (rd_run_ff) begin
         rd_cnt_in = rd_cnt_ff + 1'b1;
         if (rd_cnt_ff == LAST_IDX) begin
            rd_run_in = 1'b0;
         end
      end
   end

   assign rd_vld_in = rd_run_ff;
   assign rd_idx_in = rd_cnt_ff;

   // compare stage: earliest due entry and earliest used entry
   assign cur_used   = used_ff[rd_idx_ff];
   assign cur_pick   = picked_ff[rd_idx_ff];
   assign cur_due    = (rd_ent_ff.expiry <= req_ff.now_time);
   assign cur_better = !best_fnd_ff || (rd_ent_ff.expiry < best_ent_ff.expiry) ||
                       ((rd_ent_ff.expiry == best_ent_ff.expiry) &&
                        (rd_ent_ff.tag < best_ent_ff.tag));

   always_comb begin
      best_fnd_in = best_fnd_ff;
      best_ent_in = best_ent_ff;
      best_idx_in = best_idx_ff;
      min_any_in  = min_any_ff;
      min_exp_in  = min_exp_ff;
      if (ctl.start_scan) begin
         best_fnd_in = 1'b0;
         min_any_in  = 1'b0;
      end else if (rd_vld_ff && cur_used) begin
         if (!min_any_ff || (rd_ent_ff.expiry < min_exp_ff)) begin
            min_any_in = 1'b1;
            min_exp_in = rd_ent_ff.expiry;
         end
         if (!cur_pick && cur_due && cur_better) begin
            best_fnd_in = 1'b1;
            best_ent_in = rd_ent_ff;
            best_idx_in = rd_idx_ff;
         end
      end
   end

   // wake candidate after a scan
   always_comb begin
      wake_t_in  = wake_t_ff;
      wake_ok_in = wake_ok_ff;
      if (ctl.decide) begin
         if (is_add) begin
            wake_t_in  = req_ff.expire_time;
            wake_ok_in = !min_any_ff || (req_ff.expire_time < min_exp_ff);
         end else begin
            wake_t_in  = min_exp_ff;
            wake_ok_in = min_any_ff;
         end
      end
   end

   // periodic reinsert time, saturating
   assign reins_sum = {1'b0, req_ff.now_time} + (TIME_W + 1)'(best_ent_ff.period);
   assign reins_exp = reins_sum[TIME_W] ? TIME_MAX : reins_sum[TIME_W-1:0];

   // table writes
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = free_idx;
      wr_ent  = '{expiry: req_ff.expire_time, period: req_ff.period_us,
                  tag: req_ff.timer_tag};
      used_in   = used_ff;
      picked_in = picked_ff;
      pend_vld_in = pend_vld_ff;
      pend_tag_in = pend_tag_ff;
      if (ctl.latch_req) begin
         picked_in   = '0;
         pend_vld_in = 1'b0;
      end
      if (ctl.step) begin
         wr_addr = best_idx_ff;
         wr_ent  = '{expiry: reins_exp, period: best_ent_ff.period, tag: best_ent_ff.tag};
         picked_in[best_idx_ff] = 1'b1;
         pend_vld_in = 1'b1;
         pend_tag_in = best_ent_ff.tag;
         if (best_ent_ff.period != '0) begin
            wr_en = 1'b1;
         end else begin
            used_in[best_idx_ff] = 1'b0;
         end
      end
      if (ctl.load_final && is_add && !full) begin
         wr_en = 1'b1;
         used_in[free_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_ent;
      end
      rd_ent_ff <= slot_mem[rd_cnt_ff];
   end

   // clamped wake delay
   assign diff  = {1'b0, wake_t_ff} - {1'b0, req_ff.now_time};
   assign delay = (!diff[TIME_W] && (diff[TIME_W-1:0] >= MIN_DELAY)) ?
                  diff[TIME_W-1:0] : MIN_DELAY;

   // output register
   always_comb begin
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ready;
      if (ctl.step && pend_vld_ff) begin
         rsp_in             = '0;
         rsp_in.fired_valid = 1'b1;
         rsp_in.fired_tag   = pend_tag_ff;
         rsp_vld_in         = 1'b1;
      end
      if (ctl.load_final) begin
         rsp_in      = '0;
         rsp_in.last = 1'b1;
         rsp_vld_in  = 1'b1;
         if (is_add && full) begin
            rsp_in.full_error = 1'b1;
         end else begin
            if (is_add) begin
               rsp_in.new_earliest = wake_ok_ff;
            end else begin
               rsp_in.fired_valid = pend_vld_ff;
               rsp_in.fired_tag   = pend_vld_ff ? pend_tag_ff : '0;
            end
            if (wake_ok_ff) begin
               rsp_in.wake_valid    = 1'b1;
               rsp_in.wake_time     = wake_t_ff;
               rsp_in.wake_delay_us = delay;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pend_tag_ff <= pend_tag_in;
      rd_cnt_ff   <= rd_cnt_in;
      rd_idx_ff   <= rd_idx_in;
      best_ent_ff <= best_ent_in;
      best_idx_ff <= best_idx_in;
      min_exp_ff  <= min_exp_in;
      wake_t_ff   <= wake_t_in;
      wake_ok_ff  <= wake_ok_in;
      rsp_ff      <= rsp_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         picked_ff   <= '0;
         pend_vld_ff <= 1'b0;
         rd_run_ff   <= 1'b0;
         rd_vld_ff   <= 1'b0;
         best_fnd_ff <= 1'b0;
         min_any_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         used_ff     <= used_in;
         picked_ff   <= picked_in;
         pend_vld_ff <= pend_vld_in;
         rd_run_ff   <= rd_run_in;
         rd_vld_ff   <= rd_vld_in;
         best_fnd_ff <= best_fnd_in;
         min_any_ff  <= min_any_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // status to controller
   assign sts.scan_done  = rd_vld_ff && (rd_idx_ff == LAST_IDX);
   assign sts.best_found = best_fnd_ff;
   assign sts.pend_valid = pend_vld_ff;
   assign sts.out_free   = out_free;
   assign sts.table_full = full;
   assign sts.is_tick    = (req_ff.cmd == CMD_TICK);

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

### sv/dtq_ctrl.sv
module dtq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  dtq_pkg::dtq_sts_type sts,
   output dtq_pkg::dtq_cmd_type ctl
);
   import dtq_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_MID    = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   logic [2:0] state_ff, state_in;

   // sequencing of scans, fires and the final transaction
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.latch_req = 1'b1;
               state_in      = S_START;
            end
         end
         S_START: begin
            if (!sts.is_tick && sts.table_full) begin
               state_in = S_OUT;
            end else begin
               ctl.start_scan = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            ctl.decide = 1'b1;
            if (sts.is_tick && sts.best_found) begin
               state_in = S_MID;
            end else begin
               state_in = S_OUT;
            end
         end
         S_MID: begin
            if (!sts.pend_valid || sts.out_free) begin
               ctl.step       = 1'b1;
               ctl.start_scan = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               ctl.load_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/deadline_timer_queue_top.sv
// add: the request is scanned against the table before the result; a full table answers without a scan
// tick firing n timers: one slot-memory scan per fired timer plus a final scan, bounded by the
// single read port of the slot memory
// one transaction in flight; the next is taken while the last result waits in its register
// synchronous active-high reset empties the table (valid bits) and the output register;
// slot contents are not cleared and no clearing pass is run
module deadline_timer_queue_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dtq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dtq_pkg::rsp_type rsp_data
);
   import dtq_pkg::*;

   dtq_cmd_type ctl;
   dtq_sts_type sts;

   // controller
   dtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // table, scan and output datapath
   dtq_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/dtq_checker.sv
module dtq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input dtq_pkg::rsp_type rsp_data
);
   import dtq_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken twice in a row");

   // dropped add reports nothing else
   a_full_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.full_error |->
         rsp_data.last && !rsp_data.wake_valid && !rsp_data.fired_valid &&
         !rsp_data.new_earliest)
      else $error("full error mixed with other report");

   // wake report only on the final result and never below the floor
   a_wake_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.wake_valid |->
         rsp_data.last && (rsp_data.wake_delay_us >= MIN_DELAY))
      else $error("bad wake report");

   // intermediate results are always fired timers
   a_mid_fired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.fired_valid && !rsp_data.wake_valid)
      else $error("non-final result without a fired timer");

endmodule

bind deadline_timer_queue_top dtq_checker u_dtq_checker (.*);

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import dtq_pkg::*;

   localparam int MAX_IDLE    = 13;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 8000;
   localparam int RAND_ITEMS  = 190;
   localparam int MAX_FIRE    = 32;
   localparam int END_WAIT    = 150;

   // timer table mirror and the queue of results still owed by the block
   class timer_scoreboard;
      bit                used   [TABLE_DEPTH];
      bit [TIME_W-1:0]   expiry [TABLE_DEPTH];
      bit [PER_W-1:0]    period [TABLE_DEPTH];
      bit [TAG_W-1:0]    tag    [TABLE_DEPTH];
      rsp_type           timer_events_q [$];
      int errors    = 0;
      int n_items   = 0;
      int n_checked = 0;
      int n_dropped = 0;
      int n_fired   = 0;
      int max_burst = 0;

      function void report(string msg);
         $display("error: %s", msg);
         errors++;
      endfunction

      function int slots_in_use();
         int cnt = 0;
         foreach (used[i]) cnt += used[i];
         return cnt;
      endfunction

      function int outstanding();
         return timer_events_q.size();
      endfunction

      // wake delay with the 100 us floor
      function bit [TIME_W-1:0] wake_gap(bit [TIME_W-1:0] t, bit [TIME_W-1:0] now);
         if (t > now && t - now >= MIN_DELAY) return t - now;
         return MIN_DELAY;
      endfunction

      // earliest expiry among live slots, 0 if the table is empty
      function bit earliest_expiry(output bit [TIME_W-1:0] m);
         bit any = 0;
         m = '0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (used[i] && (!any || expiry[i] < m)) begin
               m   = expiry[i];
               any = 1;
            end
         end
         return any;
      endfunction

      function void insert_timer(req_type r);
         int              free_idx = -1;
         bit              any;
         bit [TIME_W-1:0] m;
         rsp_type         o;
         o = '0;
         o.last = 1'b1;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!used[i] && free_idx < 0) free_idx = i;
         end
         if (free_idx < 0) begin
            o.full_error = 1'b1;
            n_dropped++;
         end else begin
            any = earliest_expiry(m);
            used[free_idx]   = 1'b1;
            expiry[free_idx] = r.expire_time;
            period[free_idx] = r.period_us;
            tag[free_idx]    = r.timer_tag;
            if (!any || r.expire_time < m) begin
               o.new_earliest  = 1'b1;
               o.wake_valid    = 1'b1;
               o.wake_time     = r.expire_time;
               o.wake_delay_us = wake_gap(r.expire_time, r.now_time);
            end
         end
         timer_events_q.push_back(o);
      endfunction

      function void run_tick(req_type r);
         int              order [$];
         bit              picked [TABLE_DEPTH];
         int              best;
         int              s;
         bit              any;
         bit [TIME_W-1:0] m;
         bit [TIME_W:0]   sum;
         rsp_type         o;
         picked = '{default: 1'b0};
         // pick expired timers by expiry, then tag, then slot index
         for (int k = 0; k < MAX_FIRE; k++) begin
            best = -1;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (used[i] && !picked[i] && expiry[i] <= r.now_time) begin
                  if (best < 0 || expiry[i] < expiry[best] ||
                      (expiry[i] == expiry[best] && tag[i] < tag[best]))
                     best = i;
               end
            end
            if (best < 0) break;
            picked[best] = 1'b1;
            order.push_back(best);
         end
         // one-shot timers leave, periodic ones come back at now plus period
         foreach (order[k]) begin
            s = order[k];
            if (period[s] != '0) begin
               sum = {1'b0, r.now_time} + period[s];
               expiry[s] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            end else begin
               used[s] = 1'b0;
            end
         end
         any = earliest_expiry(m);
         n_fired += order.size();
         if (order.size() > max_burst) max_burst = order.size();
         // results, the wake report rides on the last one
         for (int k = 0; k < ((order.size() == 0) ? 1 : order.size()); k++) begin
            o = '0;
            if (order.size() != 0) begin
               o.fired_valid = 1'b1;
               o.fired_tag   = tag[order[k]];
            end
            if (k == order.size() - 1 || order.size() == 0) begin
               o.last = 1'b1;
               if (any) begin
                  o.wake_valid    = 1'b1;
                  o.wake_time     = m;
                  o.wake_delay_us = wake_gap(m, r.now_time);
               end
            end
            timer_events_q.push_back(o);
         end
      endfunction

      function void note_request(req_type r);
         n_items++;
         if (r.cmd == CMD_ADD) insert_timer(r);
         else run_tick(r);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (timer_events_q.size() == 0) begin
            report($sformatf("result %0d arrived with nothing pending", n_checked));
            return;
         end
         want = timer_events_q.pop_front();
         if (got.fired_valid !== want.fired_valid)
            report($sformatf("result %0d fired_valid %0h want %0h",
                             n_checked, got.fired_valid, want.fired_valid));
         if (got.fired_tag !== want.fired_tag)
            report($sformatf("result %0d fired_tag %0h want %0h",
                             n_checked, got.fired_tag, want.fired_tag));
         if (got.last !== want.last)
            report($sformatf("result %0d last %0h want %0h", n_checked, got.last, want.last));
         if (got.new_earliest !== want.new_earliest)
            report($sformatf("result %0d new_earliest %0h want %0h",
                             n_checked, got.new_earliest, want.new_earliest));
         if (got.full_error !== want.full_error)
            report($sformatf("result %0d full_error %0h want %0h",
                             n_checked, got.full_error, want.full_error));
         if (got.wake_valid !== want.wake_valid)
            report($sformatf("result %0d wake_valid %0h want %0h",
                             n_checked, got.wake_valid, want.wake_valid));
         if (got.wake_time !== want.wake_time)
            report($sformatf("result %0d wake_time %0h want %0h",
                             n_checked, got.wake_time, want.wake_time));
         if (got.wake_delay_us !== want.wake_delay_us)
            report($sformatf("result %0d wake_delay_us %0h want %0h",
                             n_checked, got.wake_delay_us, want.wake_delay_us));
         n_checked++;
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   timer_scoreboard sb = new();
   bit calm     = 1'b0;
   bit hold_rsp = 1'b0;
   int sent     = 0;
   int idle_cycles = 0;
   int periodic_budget = 8;

   deadline_timer_queue_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // transaction monitors on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAIL deadline_timer_queue_top");
            $finish;
         end
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin : rsp_side
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   function automatic req_type mk_req(logic c, logic [TAG_W-1:0] tg, logic [TIME_W-1:0] ex,
                                      logic [PER_W-1:0] pe, logic [TIME_W-1:0] nw);
      req_type r;
      r.cmd         = c;
      r.timer_tag   = tg;
      r.expire_time = ex;
      r.period_us   = pe;
      r.now_time    = nw;
      return r;
   endfunction

   function automatic logic [TIME_W-1:0] rand_time63();
      return TIME_W'({$urandom, $urandom});
   endfunction

   function automatic logic [TAG_W-1:0] rand_tag();
      if ($urandom_range(0, 3) == 0) return TAG_W'($urandom_range(0, 3));
      return TAG_W'($urandom_range(0, 65535));
   endfunction

   // periodic timers never leave the table, so they are rationed
   function automatic logic [PER_W-1:0] rand_period();
      if (periodic_budget > 0 && $urandom_range(0, 11) == 0) begin
         periodic_budget--;
         if ($urandom_range(0, 1) == 0) return PER_W'($urandom_range(1, 2000));
         return {8'($urandom), 32'($urandom)};
      end
      return '0;
   endfunction

   // offer one transaction after a random gap, return once it is taken
   task automatic send_req(input req_type r);
      int gap;
      gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic wait_drained();
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   task automatic send_tick(input logic [TIME_W-1:0] now);
      send_req(mk_req(CMD_TICK, rand_tag(), rand_time63(), {8'($urandom), 32'($urandom)}, now));
   endtask

   // mixed adds and ticks around a moving time
   task automatic mixed_run(input logic [TIME_W-1:0] base, input int count);
      logic [TIME_W-1:0] cur;
      logic [TIME_W-1:0] ex;
      int                roll;
      cur = base;
      repeat (count) begin
         if ($urandom_range(0, 9) < 4) begin
            cur = cur + TIME_W'($urandom_range(0, 1200));
            send_tick(cur);
         end else begin
            roll = $urandom_range(0, 9);
            if (roll == 0) ex = rand_time63();
            else if (roll == 1) ex = cur - TIME_W'($urandom_range(0, 500));
            else ex = cur + TIME_W'($urandom_range(0, 2500));
            send_req(mk_req(CMD_ADD, rand_tag(), ex, rand_period(), cur));
         end
      end
      // closing tick, sometimes near the top of time to clear the table
      if ($urandom_range(0, 3) == 0) send_tick(TIME_MAX - TIME_W'($urandom_range(0, 1)));
      else send_tick(cur + TIME_W'($urandom_range(0, 3000)));
   endtask

   // adds until the table overflows, then a tick that fires everything due
   task automatic fill_run(input logic [TIME_W-1:0] base);
      while (sb.slots_in_use() < TABLE_DEPTH)
         send_req(mk_req(CMD_ADD, rand_tag(), base + TIME_W'($urandom_range(0, 3000)),
                         '0, base));
      repeat (2)
         send_req(mk_req(CMD_ADD, rand_tag(), rand_time63(), rand_period(), base));
      send_tick(base + TIME_W'(5000));
   endtask

   initial begin : stimulus
      logic [TIME_W-1:0] base;
      int                rand_start;
      bit                held;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, earliest rules, floor, ordering, saturation
      send_req(mk_req(CMD_TICK, '0, '0, '0, '0));
      send_req(mk_req(CMD_ADD, 16'h0000, '0, '0, '0));
      send_req(mk_req(CMD_ADD, 16'h1234, 63'd1000, '0, 63'd950));
      send_req(mk_req(CMD_ADD, 16'h0002, 63'd5000, '0, 63'd1000));
      send_req(mk_req(CMD_ADD, 16'h0003, 63'd1000, '0, 63'd1000));
      send_tick(63'd0);
      send_req(mk_req(CMD_ADD, 16'h0004, 63'd400, '0, 63'd100));
      send_req(mk_req(CMD_ADD, 16'h0005, 63'd200, '0, 63'd900));
      send_req(mk_req(CMD_ADD, 16'h0007, 63'd3000, '0, 63'd1000));
      send_req(mk_req(CMD_ADD, 16'h0007, 63'd3000, '0, 63'd1000));
      send_req(mk_req(CMD_ADD, 16'hFFFF, 63'd2500, '1, 63'd1000));
      send_req(mk_req(CMD_ADD, 16'h0042, 63'd6000, 40'd250, 63'd5000));
      send_tick(63'd150);
      send_tick(63'd1000);
      send_tick(63'd3000);
      send_req(mk_req(CMD_ADD, 16'h0F0F, TIME_MAX - 63'd50, '1, TIME_MAX - 63'd1000));
      send_req(mk_req(CMD_ADD, 16'h8001, TIME_MAX, '0, TIME_MAX));
      send_tick(TIME_MAX - 63'd40);
      send_tick(TIME_MAX);
      send_tick(63'd7000);
      req_valid <= 1'b0;
      wait_drained();

      // random episodes
      rand_start = sent;
      held       = 1'b0;
      while (sent - rand_start < RAND_ITEMS) begin
         calm = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 2))
            0:       base = TIME_W'($urandom_range(0, 100000));
            1:       base = rand_time63();
            default: base = TIME_MAX - TIME_W'($urandom_range(100000, 2000000));
         endcase
         if (!held && sent - rand_start > 70) begin
            // receiver holds off while the sender keeps offering
            held     = 1'b1;
            hold_rsp = 1'b1;
            calm     = 1'b1;
            mixed_run(base, 8);
            calm = 1'b0;
            req_valid <= 1'b0;
            wait_drained();
         end else if ($urandom_range(0, 4) == 0) begin
            fill_run(base);
         end else begin
            mixed_run(base, $urandom_range(6, 14));
         end
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      // drain, then let the block sit to catch stray results
      wait_drained();
      repeat (END_WAIT) @(posedge clock);
      $display("run: %0d transactions in, %0d results checked, %0d adds dropped on full table",
               sb.n_items, sb.n_checked, sb.n_dropped);
      $display("run: %0d timers fired, up to %0d in one tick", sb.n_fired, sb.max_burst);
      if (sb.errors == 0) begin
         $display("PASS deadline_timer_queue_top");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("FAIL deadline_timer_queue_top");
      end
      $finish;
   end

endmodule
